// ----- design/linear_ranking_selector_unit_assert.svh -----
// assertion macros used by the linear ranking selector datapath
// needs nothing else; included inside the lrs_dp module body
`ifndef LINEAR_RANKING_SELECTOR_UNIT_ASSERT_SVH
`define LINEAR_RANKING_SELECTOR_UNIT_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define LRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous active-low reset
`define LRS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/lrs_pkg.sv -----
// shared types, codes and constants of the linear ranking selector
// no dependencies
`timescale 1ns / 1ps

package lrs_pkg;

    localparam int MAX_CANDIDATES = 256;
    localparam int ID_WIDTH       = 16;
    localparam int CNT_W          = $clog2(MAX_CANDIDATES + 1);
    localparam int IDX_W          = $clog2(MAX_CANDIDATES);
    localparam int P_W            = 18;
    localparam int INR_W          = 17;
    localparam int RF_W           = 16;
    localparam int CHOICE_W       = RF_W + CNT_W;
    localparam int SUM_W          = CHOICE_W + 2;
    localparam int DIV_CNT_W      = $clog2(P_W + 1);

    localparam logic [P_W-1:0]   ONE_Q16     = P_W'(65536);
    localparam logic [P_W-1:0]   TWO_Q16     = P_W'(131072);
    localparam logic [INR_W-1:0] INERTIA_ONE = INR_W'(65536);

    // operation codes
    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_SELECT = 3'd1,
        OP_END    = 3'd2,
        OP_UPDATE = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_PMIN    = 2'd0;
    localparam logic [1:0] CFG_PMAX    = 2'd1;
    localparam logic [1:0] CFG_INERTIA = 2'd2;

    typedef struct packed {
        logic [2:0]          operation;
        logic [ID_WIDTH-1:0] candidate_id;
        logic [RF_W-1:0]     random_fraction;
        logic [15:0]         very_good_count;
        logic [15:0]         good_count;
        logic [15:0]         bad_count;
    } t_in_item;

    typedef struct packed {
        logic [15:0]      selected_id;
        logic [7:0]       selected_position;
        logic [1:0]       status;
        logic [P_W-1:0]   pressure_now;
        logic [CNT_W-1:0] list_length;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic load_wr;
        logic set_full;
        logic set_empty;
        logic sel_init;
        logic div_step;
        logic walk_init;
        logic walk_step;
        logic fetch;
        logic grab;
        logic shift_step;
        logic sel_end;
        logic copy_init;
        logic copy_step;
        logic copy_end;
        logic upd_mul1;
        logic upd_mul2;
        logic clear;
        logic emit;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        t_op  op;
        logic store_full;
        logic list_empty;
        logic single;
        logic div_done;
        logic walk_more;
        logic shift_done;
        logic copy_done;
    } t_dp_stat;

    // clamp a pressure into [1.0, 2.0]
    function automatic logic [P_W-1:0] sat_pressure(input logic [P_W-1:0] v);
        logic [P_W-1:0] r;
        if (v < ONE_Q16) begin
            r = ONE_Q16;
        end else if (v > TWO_Q16) begin
            r = TWO_Q16;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- design/lrs_ctrl.sv -----
// controller state machine of the linear ranking selector
// depends on lrs_pkg
`timescale 1ns / 1ps

module lrs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output lrs_pkg::t_dp_cmd  o_cmd,
    input  lrs_pkg::t_dp_stat i_stat
);
    import lrs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_DIV,
        S_WALK,
        S_FETCH,
        S_GRAB,
        S_SHIFT,
        S_COPY,
        S_UPD2,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;

    // next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_FINISH;
                case (i_stat.op)
                    OP_LOAD: begin
                        if (i_stat.store_full) begin
                            o_cmd.set_full = 1'b1;
                        end else begin
                            o_cmd.load_wr = 1'b1;
                        end
                    end
                    OP_SELECT: begin
                        if (i_stat.list_empty) begin
                            o_cmd.set_empty = 1'b1;
                        end else begin
                            o_cmd.sel_init = 1'b1;
                            n_state        = i_stat.single ? S_FETCH : S_DIV;
                        end
                    end
                    OP_END: begin
                        o_cmd.copy_init = 1'b1;
                        n_state         = S_COPY;
                    end
                    OP_UPDATE: begin
                        o_cmd.upd_mul1 = 1'b1;
                        n_state        = S_UPD2;
                    end
                    OP_CLEAR: begin
                        o_cmd.clear = 1'b1;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.walk_init = 1'b1;
                    n_state         = S_WALK;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_WALK: begin
                if (i_stat.walk_more) begin
                    o_cmd.walk_step = 1'b1;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_GRAB;
            end
            S_GRAB: begin
                o_cmd.grab       = 1'b1;
                o_cmd.shift_step = 1'b1;
                n_state          = S_SHIFT;
            end
            S_SHIFT: begin
                if (i_stat.shift_done) begin
                    o_cmd.sel_end = 1'b1;
                    n_state       = S_FINISH;
                end else begin
                    o_cmd.shift_step = 1'b1;
                end
            end
            S_COPY: begin
                if (i_stat.copy_done) begin
                    o_cmd.copy_end = 1'b1;
                    n_state        = S_FINISH;
                end else begin
                    o_cmd.copy_step = 1'b1;
                end
            end
            S_UPD2: begin
                o_cmd.upd_mul2 = 1'b1;
                n_state        = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- design/lrs_dp.sv -----
// datapath of the linear ranking selector: lists, divider, weight walk, pressure
// depends on lrs_pkg and linear_ranking_selector_unit_assert.svh
`timescale 1ns / 1ps

module lrs_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [17:0]        i_cfg_data,
    input  lrs_pkg::t_in_item  i_in_data,
    input  lrs_pkg::t_dp_cmd   i_cmd,
    output lrs_pkg::t_dp_stat  o_stat,
    output lrs_pkg::t_out_item o_out_data
);
    import lrs_pkg::*;

    `include "linear_ranking_selector_unit_assert.svh"

    // list memories
    logic [ID_WIDTH-1:0] ranked_mem [MAX_CANDIDATES];
    logic [ID_WIDTH-1:0] picked_mem [MAX_CANDIDATES];
    logic [ID_WIDTH-1:0] r_rk_rd, r_pk_rd;

    // control state
    logic [P_W-1:0]       r_pmin, r_pmax, r_pressure;
    logic [INR_W-1:0]     r_inertia;
    logic [CNT_W-1:0]     r_rc, r_pc;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic                 r_pend;

    // payload
    t_in_item            r_item;
    t_out_item           r_out;
    logic [1:0]          r_status;
    logic [ID_WIDTH-1:0] r_sel_id;
    logic [IDX_W-1:0]    r_pos;
    logic [CHOICE_W-1:0] r_choice;
    logic [P_W-2:0]      r_base;
    logic [P_W-1:0]      r_a, r_quo, r_q;
    logic [IDX_W-1:0]    r_den, r_rem, r_r;
    logic [CNT_W-1:0]    r_k, r_idx, r_wa;
    logic [SUM_W-1:0]    r_sum;
    logic [P_W+INR_W-1:0] r_prod;
    logic [INR_W-1:0]    r_inv;
    logic [P_W-1:0]      r_target;

    // select setup
    logic [P_W-1:0] p_sat, a_now;
    assign p_sat = sat_pressure(r_pressure);
    assign a_now = (p_sat - ONE_Q16) << 1;

    // one restoring division step of 2(p-1) by n-1
    logic [IDX_W:0] div_tmp, div_sub;
    logic           div_ge;
    assign div_tmp = {r_rem, r_quo[P_W-1]};
    assign div_sub = div_tmp - {1'b0, r_den};
    assign div_ge  = (div_tmp >= {1'b0, r_den});

    // step quotient and remainder of 2(p-1)(n-1-k)/(n-1) from k to k+1
    logic [P_W-1:0]   adv_q_in, adv_q_out;
    logic [IDX_W-1:0] adv_r_in, adv_r_out;
    logic             adv_lt;
    assign adv_q_in  = i_cmd.walk_init ? r_a : r_q;
    assign adv_r_in  = i_cmd.walk_init ? '0 : r_r;
    assign adv_lt    = (adv_r_in < r_rem);
    assign adv_r_out = adv_lt ? IDX_W'({1'b0, adv_r_in} + {1'b0, r_den} - {1'b0, r_rem})
                              : adv_r_in - r_rem;
    assign adv_q_out = adv_q_in - r_quo - P_W'(adv_lt);

    logic [P_W-1:0] weight;
    assign weight = P_W'(r_base) + r_q;

    // pressure target
    logic [P_W-1:0]   pmin_s, pmax_s, tgt_half, tgt;
    logic [INR_W-1:0] in_c;
    logic signed [P_W:0] p_diff;
    assign pmin_s   = sat_pressure(r_pmin);
    assign pmax_s   = sat_pressure(r_pmax);
    assign in_c     = (r_inertia > INERTIA_ONE) ? INERTIA_ONE : r_inertia;
    assign p_diff   = $signed({1'b0, r_pressure}) - $signed({1'b0, pmin_s});
    assign tgt_half = P_W'($signed({1'b0, pmin_s}) + (p_diff >>> 1));

    always_comb begin
        if (r_item.very_good_count != '0) begin
            tgt = pmax_s;
        end else if (r_item.good_count != '0) begin
            tgt = tgt_half;
        end else if (r_item.bad_count != '0) begin
            tgt = pmin_s;
        end else begin
            tgt = r_pressure;
        end
    end

    // status toward the controller
    assign o_stat.op         = t_op'(r_item.operation);
    assign o_stat.store_full = ({1'b0, r_rc} + {1'b0, r_pc}) >= (CNT_W + 1)'(MAX_CANDIDATES);
    assign o_stat.list_empty = (r_rc == '0);
    assign o_stat.single     = (r_rc == CNT_W'(1));
    assign o_stat.div_done   = (r_div_cnt == '0);
    assign o_stat.walk_more  = (r_k < r_rc) && ({2'b00, r_choice} > r_sum);
    assign o_stat.shift_done = !r_pend && (r_idx >= r_rc);
    assign o_stat.copy_done  = !r_pend && (r_idx >= r_pc);
    assign o_out_data        = r_out;

    // memory addresses
    logic [IDX_W-1:0]    rk_ra;
    logic                rk_we;
    logic [IDX_W-1:0]    rk_wa;
    logic [ID_WIDTH-1:0] rk_wd;
    assign rk_ra = i_cmd.fetch ? r_pos : r_idx[IDX_W-1:0];

    always_comb begin
        rk_we = 1'b0;
        rk_wa = r_wa[IDX_W-1:0];
        rk_wd = r_rk_rd;
        if (i_cmd.load_wr) begin
            rk_we = 1'b1;
            rk_wa = r_rc[IDX_W-1:0];
            rk_wd = r_item.candidate_id;
        end else if (i_cmd.shift_step && r_pend) begin
            rk_we = 1'b1;
        end else if (i_cmd.copy_step && r_pend) begin
            rk_we = 1'b1;
            rk_wd = r_pk_rd;
        end
    end

    // ranked list memory
    always_ff @(posedge i_clk) begin
        if (rk_we) begin
            ranked_mem[rk_wa] <= rk_wd;
        end
        r_rk_rd <= ranked_mem[rk_ra];
    end

    // picked list memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.sel_end) begin
            picked_mem[r_pc[IDX_W-1:0]] <= r_sel_id;
        end
        r_pk_rd <= picked_mem[r_idx[IDX_W-1:0]];
    end

    // control state: registers, counts, pressure, move pipeline flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pmin     <= ONE_Q16;
            r_pmax     <= ONE_Q16;
            r_inertia  <= '0;
            r_pressure <= ONE_Q16;
            r_rc       <= '0;
            r_pc       <= '0;
            r_div_cnt  <= '0;
            r_pend     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PMIN:    r_pmin    <= i_cfg_data;
                    CFG_PMAX:    r_pmax    <= i_cfg_data;
                    CFG_INERTIA: r_inertia <= i_cfg_data[INR_W-1:0];
                    default:     r_pmin    <= r_pmin;
                endcase
            end
            if (i_cmd.load_wr) begin
                r_rc <= r_rc + CNT_W'(1);
            end
            if (i_cmd.sel_end) begin
                r_rc <= r_rc - CNT_W'(1);
                r_pc <= r_pc + CNT_W'(1);
            end
            if (i_cmd.copy_end) begin
                r_rc <= r_rc + r_pc;
                r_pc <= '0;
            end
            if (i_cmd.clear) begin
                r_rc <= '0;
                r_pc <= '0;
            end
            if (i_cmd.upd_mul2) begin
                r_pressure <= P_W'(({1'b0, r_prod}
                              + (P_W + INR_W + 1)'(r_inv) * (P_W + INR_W + 1)'(r_target))
                              >> 16);
            end
            if (i_cmd.sel_init) begin
                r_div_cnt <= DIV_CNT_W'(P_W);
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
            end
            if (i_cmd.fetch || i_cmd.copy_init) begin
                r_pend <= 1'b0;
            end else if (i_cmd.shift_step) begin
                r_pend <= (r_idx < r_rc);
            end else if (i_cmd.copy_step) begin
                r_pend <= (r_idx < r_pc);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item   <= i_in_data;
            r_status <= ST_OK;
            r_sel_id <= '0;
            r_pos    <= '0;
        end
        if (i_cmd.set_full) begin
            r_status <= ST_FULL;
        end
        if (i_cmd.set_empty) begin
            r_status <= ST_EMPTY;
        end
        // select setup and divider
        if (i_cmd.sel_init) begin
            r_choice <= CHOICE_W'(r_item.random_fraction) * CHOICE_W'(r_rc);
            r_base   <= (P_W-1)'(TWO_Q16 - p_sat);
            r_a      <= a_now;
            r_den    <= IDX_W'(r_rc - CNT_W'(1));
            r_quo    <= a_now;
            r_rem    <= '0;
            r_pos    <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? div_sub[IDX_W-1:0] : div_tmp[IDX_W-1:0];
            r_quo <= {r_quo[P_W-2:0], div_ge};
        end
        // weight walk
        if (i_cmd.walk_init) begin
            r_sum <= SUM_W'(r_base) + SUM_W'(r_a);
            r_q   <= adv_q_out;
            r_r   <= adv_r_out;
            r_k   <= CNT_W'(1);
            r_pos <= '0;
        end
        if (i_cmd.walk_step) begin
            r_sum <= r_sum + SUM_W'(weight);
            r_q   <= adv_q_out;
            r_r   <= adv_r_out;
            r_pos <= r_k[IDX_W-1:0];
            r_k   <= r_k + CNT_W'(1);
        end
        // list moves
        if (i_cmd.fetch) begin
            r_idx <= {1'b0, r_pos} + CNT_W'(1);
            r_wa  <= {1'b0, r_pos};
        end
        if (i_cmd.grab) begin
            r_sel_id <= r_rk_rd;
        end
        if (i_cmd.copy_init) begin
            r_idx <= '0;
            r_wa  <= r_rc;
        end
        if ((i_cmd.shift_step && (r_idx < r_rc)) || (i_cmd.copy_step && (r_idx < r_pc))) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        if ((i_cmd.shift_step || i_cmd.copy_step) && r_pend) begin
            r_wa <= r_wa + CNT_W'(1);
        end
        // pressure update, first product
        if (i_cmd.upd_mul1) begin
            r_prod   <= (P_W + INR_W)'(in_c) * (P_W + INR_W)'(r_pressure);
            r_inv    <= INERTIA_ONE - in_c;
            r_target <= tgt;
        end
        if (i_cmd.emit) begin
            r_out.selected_id       <= 16'(r_sel_id);
            r_out.selected_position <= 8'(r_pos);
            r_out.status            <= r_status;
            r_out.pressure_now      <= r_pressure;
            r_out.list_length       <= r_rc;
        end
    end

    // both lists together never exceed the store
    `LRS_ASSERT_IMP(a_store_bound, i_clk, i_rst_n, 1'b1, (({1'b0, r_rc} + {1'b0, r_pc}) <= (CNT_W + 1)'(MAX_CANDIDATES)), "ranked plus picked exceeds store")
    // incremental remainder stays below the divisor during the walk
    `LRS_ASSERT_IMP(a_walk_rem, i_clk, i_rst_n, i_cmd.walk_step, (r_r < r_den), "walk remainder not below divisor")
    // a finished select moves exactly one id to the picked list
    `LRS_ASSERT_NXT(a_sel_moves, i_clk, i_rst_n, i_cmd.sel_end, ((r_rc == CNT_W'($past(r_rc) - CNT_W'(1))) && (r_pc == CNT_W'($past(r_pc) + CNT_W'(1)))), "select did not move one id")

endmodule

// ----- design/linear_ranking_selector_unit.sv -----
// top level of the linear ranking selector: controller plus datapath
// depends on lrs_pkg, lrs_ctrl, lrs_dp
//
//   channel  | signals                               | direction
//   ---------+---------------------------------------+----------
//   input    | i_in_valid, o_in_ready, i_in_data      | in
//   result   | o_out_valid, i_out_ready, o_out_data   | out
//   config   | i_cfg_we, i_cfg_index, i_cfg_data      | in
//
// one item at a time
// select runs a divider and a walk of one weight per cycle, both skipped for a single id,
// and a list shift of one entry per cycle on the memory port
// end of batch moves the picked ids back to the ranked list, one copy per cycle
// reset is synchronous and clears counts, pressure and configuration registers; memories need no clearing
// a held result does not block the next transfer in, only the completion of that next item
`timescale 1ns / 1ps

module linear_ranking_selector_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lrs_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lrs_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [17:0]        i_cfg_data
);
    import lrs_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer
    lrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // lists and arithmetic
    lrs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

endmodule

// ----- verif/tb_linear_ranking_selector_unit.sv -----
// self-checking testbench for linear_ranking_selector_unit
// depends on lrs_pkg and the selector rtl; predicts each result and compares field by field
`timescale 1ns / 1ps

module tb_linear_ranking_selector_unit;
    import lrs_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_data;
    logic      cfg_we;
    logic [1:0]  cfg_index;
    logic [17:0] cfg_data;

    linear_ranking_selector_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    // predictor state
    logic [15:0] rank_list [MAX_CANDIDATES];
    int unsigned rank_len;
    logic [15:0] pick_list [MAX_CANDIDATES];
    int unsigned pick_len;
    logic [17:0] cur_pressure;
    logic [17:0] reg_pmin, reg_pmax;
    logic [16:0] reg_inertia;

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    int errors;
    int results_seen;
    longint cycle_count;
    int sel_seen, full_seen, empty_seen;

    function automatic logic [17:0] clamp_p(logic [17:0] v);
        if (v < 18'd65536) return 18'd65536;
        if (v > 18'd131072) return 18'd131072;
        return v;
    endfunction

    function automatic longint rank_weight(longint p, longint n, longint k);
        return (131072 - p) + (2 * (p - 65536) * (n - 1 - k)) / (n - 1);
    endfunction

    function automatic int unsigned draw_position(int unsigned rf, int unsigned n);
        longint p, choice, acc;
        int unsigned pos;
        p = clamp_p(cur_pressure);
        choice = longint'(rf) * n;
        pos = 0;
        if (n <= 1) return 0;
        acc = rank_weight(p, n, 0);
        if (choice < acc) return 0;
        for (int unsigned k = 1; k < n && choice > acc; k++) begin
            acc += rank_weight(p, n, k);
            pos = k;
        end
        return pos;
    endfunction

    // apply one item to the predictor and return the expected result
    function automatic t_out_item predict_item(t_in_item it);
        t_out_item r;
        int unsigned pos;
        longint pmin, pmax, p, tgt, inr, d;
        r = '0;
        case (it.operation)
            OP_LOAD: begin
                if (rank_len + pick_len >= MAX_CANDIDATES) r.status = ST_FULL;
                else begin
                    rank_list[rank_len] = it.candidate_id;
                    rank_len++;
                end
            end
            OP_SELECT: begin
                if (rank_len == 0) r.status = ST_EMPTY;
                else begin
                    pos = draw_position(it.random_fraction, rank_len);
                    r.selected_id = rank_list[pos];
                    r.selected_position = pos[7:0];
                    for (int unsigned i = pos; i + 1 < rank_len; i++)
                        rank_list[i] = rank_list[i+1];
                    rank_len--;
                    if (pick_len < MAX_CANDIDATES) begin
                        pick_list[pick_len] = r.selected_id;
                        pick_len++;
                    end
                end
            end
            OP_END: begin
                for (int unsigned i = 0; i < pick_len && rank_len < MAX_CANDIDATES; i++) begin
                    rank_list[rank_len] = pick_list[i];
                    rank_len++;
                end
                pick_len = 0;
            end
            OP_UPDATE: begin
                pmin = clamp_p(reg_pmin);
                pmax = clamp_p(reg_pmax);
                p = cur_pressure;
                tgt = p;
                inr = (reg_inertia > 17'd65536) ? 65536 : reg_inertia;
                if (it.very_good_count != 0) tgt = pmax;
                else if (it.good_count != 0) begin
                    d = p - pmin;
                    tgt = pmin + ((d >= 0) ? d / 2 : -((-d + 1) / 2));
                end else if (it.bad_count != 0) tgt = pmin;
                cur_pressure = 18'((inr * p + (65536 - inr) * tgt) >>> 16);
            end
            OP_CLEAR: begin
                rank_len = 0;
                pick_len = 0;
            end
            default: ;
        endcase
        r.pressure_now = cur_pressure;
        r.list_length = rank_len[CNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s at result %0d: got %0d want %0d", what, results_seen, got, want);
        errors++;
    endtask

    // add one item at the tail of the pending queue
    function automatic void enqueue_item(t_in_item it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    // clock
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // driver: one transfer per pending item with a random gap
    int send_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap <= $urandom_range(0, 15);
        end else if (in_valid && !in_ready) begin
            // hold
        end else begin
            if (in_valid)
                expected_results.insert(expected_results.size(), predict_item(in_data));
            if (send_gap > 0 || pending_items.size() == 0) begin
                in_valid <= 1'b0;
                if (send_gap > 0) send_gap <= send_gap - 1;
            end else begin
                in_valid <= 1'b1;
                in_data <= pending_items.pop_front();
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            end
        end
    end

    // monitor: compare each transfer out with the oldest expectation
    int stall_left;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (out_valid && out_ready) begin
                t_out_item w;
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    w = expected_results.pop_front();
                    if (out_data.selected_id != w.selected_id)
                        report_mismatch("selected_id", out_data.selected_id, w.selected_id);
                    if (out_data.selected_position != w.selected_position)
                        report_mismatch("selected_position", out_data.selected_position,
                                        w.selected_position);
                    if (out_data.status != w.status)
                        report_mismatch("status", out_data.status, w.status);
                    if (out_data.pressure_now != w.pressure_now)
                        report_mismatch("pressure_now", out_data.pressure_now, w.pressure_now);
                    if (out_data.list_length != w.list_length)
                        report_mismatch("list_length", out_data.list_length, w.list_length);
                    if (w.status == ST_FULL) full_seen++;
                    if (w.status == ST_EMPTY) empty_seen++;
                    if (w.selected_id != 0 || w.selected_position != 0) sel_seen++;
                end
                stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
                out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
            if (cycle_count > LIMIT_CYCLES) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic t_in_item make_item(t_op op, logic [15:0] cid, logic [15:0] rf);
        t_in_item it;
        it = '0;
        it.operation = op;
        it.candidate_id = cid;
        it.random_fraction = rf;
        it.very_good_count = 16'($urandom);
        it.good_count = 16'($urandom);
        it.bad_count = 16'($urandom);
        return it;
    endfunction

    function automatic t_in_item make_update(logic [15:0] vg, logic [15:0] g, logic [15:0] b);
        t_in_item it;
        it = '0;
        it.operation = OP_UPDATE;
        it.candidate_id = 16'($urandom);
        it.random_fraction = 16'($urandom);
        it.very_good_count = vg;
        it.good_count = g;
        it.bad_count = b;
        return it;
    endfunction

    // let all queued items finish, then give the block time to go idle
    task automatic drain_block();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [17:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PMIN: reg_pmin = val;
            CFG_PMAX: reg_pmax = val;
            default: reg_inertia = val[16:0];
        endcase
    endtask

    // one random phase: a random mix of loads, selects, ends of batch, updates, rare clears and unused codes
    task automatic random_phase(int n_items);
        int cnt;
        cnt = 0;
        while (cnt < n_items) begin
            int k;
            k = $urandom_range(0, 19);
            if (k < 8) enqueue_item(make_item(OP_LOAD, 16'($urandom), 16'($urandom)));
            else if (k < 15) enqueue_item(make_item(OP_SELECT, 16'($urandom),
                                                    16'($urandom)));
            else if (k < 16) enqueue_item(make_item(OP_END, 16'($urandom),
                                                    16'($urandom)));
            else if (k < 18) enqueue_item(make_update(
                ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'd0,
                ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'd0,
                ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'd0));
            else if (k < 19 && $urandom_range(0, 9) == 0)
                enqueue_item(make_item(OP_CLEAR, 16'($urandom), 16'($urandom)));
            else enqueue_item(make_item(t_op'($urandom_range(5, 7)), 16'($urandom),
                                        16'($urandom)));
            cnt++;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_PMIN;
        cfg_data = '0;
        out_ready = 1'b0;
        errors = 0;
        results_seen = 0;
        cycle_count = 0;
        sel_seen = 0; full_seen = 0; empty_seen = 0;
        rank_len = 0; pick_len = 0;
        cur_pressure = 18'd65536;
        reg_pmin = 18'd65536; reg_pmax = 18'd65536; reg_inertia = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty select, single entry, extremes, every operation
        write_reg(CFG_PMIN, 18'd65536);
        write_reg(CFG_PMAX, 18'd131072);
        write_reg(CFG_INERTIA, 18'd0);
        enqueue_item(make_item(OP_SELECT, 16'hffff, 16'hffff));
        enqueue_item(make_item(OP_LOAD, 16'hffff, 16'h0000));
        enqueue_item(make_item(OP_SELECT, 16'h0000, 16'hffff));
        enqueue_item(make_item(OP_LOAD, 16'h0000, 16'hffff));
        enqueue_item(make_item(OP_LOAD, 16'h1234, 16'h0));
        enqueue_item(make_item(OP_LOAD, 16'habcd, 16'h0));
        enqueue_item(make_update(16'hffff, 16'h0, 16'h0));
        enqueue_item(make_item(OP_SELECT, 16'h0, 16'h0000));
        enqueue_item(make_item(OP_SELECT, 16'h0, 16'hffff));
        enqueue_item(make_item(OP_END, 16'h0, 16'h0));
        enqueue_item(make_update(16'h0, 16'hffff, 16'h0));
        enqueue_item(make_update(16'h0, 16'h0, 16'h0001));
        enqueue_item(make_update(16'h0, 16'h0, 16'h0));
        enqueue_item(make_item(t_op'(3'd5), 16'h0, 16'h0));
        enqueue_item(make_item(t_op'(3'd7), 16'hffff, 16'hffff));
        enqueue_item(make_item(OP_CLEAR, 16'h0, 16'h0));
        drain_block();

        // store full: fill to capacity, pick some, then overflow loads
        for (int i = 0; i < MAX_CANDIDATES; i++)
            enqueue_item(make_item(OP_LOAD, 16'($urandom), 16'h0));
        for (int i = 0; i < 8; i++)
            enqueue_item(make_item(OP_SELECT, 16'h0, 16'($urandom)));
        enqueue_item(make_item(OP_LOAD, 16'h5555, 16'h0));
        enqueue_item(make_item(OP_END, 16'h0, 16'h0));
        enqueue_item(make_item(OP_LOAD, 16'haaaa, 16'h0));
        enqueue_item(make_item(OP_CLEAR, 16'h0, 16'h0));
        drain_block();

        // out of range and inverted registers, full inertia
        write_reg(CFG_PMIN, 18'h3ffff);
        write_reg(CFG_PMAX, 18'd0);
        write_reg(CFG_INERTIA, 18'h1ffff);
        random_phase(100);
        drain_block();
        write_reg(CFG_PMIN, 18'd70000);
        write_reg(CFG_PMAX, 18'd120000);
        write_reg(CFG_INERTIA, 18'd32768);
        random_phase(150);
        drain_block();
        write_reg(CFG_PMIN, 18'd131072);
        write_reg(CFG_PMAX, 18'd65536);
        write_reg(CFG_INERTIA, 18'd65536);
        random_phase(100);
        drain_block();
        for (int ph = 0; ph < 3; ph++) begin
            write_reg(CFG_PMIN, 18'($urandom_range(65536, 131072)));
            write_reg(CFG_PMAX, 18'($urandom_range(65536, 131072)));
            write_reg(CFG_INERTIA, 18'($urandom_range(0, 65536)));
            random_phase(50);
            drain_block();
        end

        $display("covered %0d results: %0d picks, %0d refused loads, %0d empty selects",
                 results_seen, sel_seen, full_seen, empty_seen);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/lrs_pkg.sv
design/lrs_ctrl.sv
design/lrs_dp.sv
design/linear_ranking_selector_unit.sv
verif/tb_linear_ranking_selector_unit.sv
